/* rtl/annexb_nal_packetizer_macros.svh */
// Assertion helpers shared by the packetizer modules.
`ifndef ANNEXB_NAL_PACKETIZER_MACROS_SVH
`define ANNEXB_NAL_PACKETIZER_MACROS_SVH

// Same-cycle implication.
`define ANNEXB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("annexb assertion failed");

// Next-cycle implication.
`define ANNEXB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("annexb assertion failed");

`endif

/* rtl/annexb_pkg.sv */
package annexb_pkg;

    localparam int DEF_LOOKAHEAD_DEPTH = 5;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [15:0] MAX_PKT_RESET = 16'd4096;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_SC     = 2'd1;
    localparam logic [1:0] ERR_SC_AT_END = 2'd2;
    localparam logic [1:0] ERR_ADJ_SC    = 2'd3;

    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_NEXT,
        PH_SC,
        PH_NAL_FIRST,
        PH_BODY,
        PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        SC_NONE,
        SC_END,
        SC_3,
        SC_4
    } sc_t;

    // One classified beat, before packet marks are added.
    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data;
        logic        unit_first;
        logic        unit_last;
        logic        pts_valid;
        logic [31:0] timestamp;
        logic [1:0]  error_code;
        logic        stream_end;
    } unit_rec_t;

endpackage

/* rtl/annexb_front.sv */
module annexb_front #(
    parameter int LOOKAHEAD_DEPTH = annexb_pkg::DEF_LOOKAHEAD_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic                  q_full,
    output logic                  q_push,
    output annexb_pkg::unit_rec_t q_rec
);
    import annexb_pkg::*;

    `include "annexb_nal_packetizer_macros.svh"

    localparam int WIN = (LOOKAHEAD_DEPTH < 5) ? 5 :
                         ((LOOKAHEAD_DEPTH > 6) ? 6 : LOOKAHEAD_DEPTH);
    localparam int FILL_W = $clog2(WIN + 1);
    localparam logic [FILL_W-1:0] WIN_FILL = FILL_W'(WIN);
    localparam logic [FILL_W-1:0] ONE      = FILL_W'(1);
    localparam logic [FILL_W-1:0] THREE    = FILL_W'(3);
    localparam logic [FILL_W-1:0] FOUR     = FILL_W'(4);

    logic [7:0]        win_reg [WIN];
    logic [7:0]        win_next [WIN];
    logic [FILL_W-1:0] fill_reg, fill_next;
    phase_t            phase_reg, phase_next;
    logic [1:0]        sc_left_reg, sc_left_next;
    logic [31:0]       pic_reg, pic_next;
    logic [1:0]        err_reg, err_next;
    logic              drain_reg, drain_next;

    logic [7:0]        cur [WIN];
    logic [FILL_W-1:0] fill_cur, avail1;
    logic              accept, go, app, eof_mode, proc, cont;
    logic              do_emit, do_err, pts, ulast;
    logic [1:0]        err_code, sl;
    logic [4:0]        nal_type;
    sc_t               sc0, sc1;
    unit_rec_t         rec;

    function automatic sc_t sc_at(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [FILL_W-1:0] avail);
        sc_t r;
        if (avail == '0)
            r = SC_END;
        else if (avail >= FOUR && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h00 && b3 == 8'h01)
            r = SC_4;
        else if (avail >= THREE && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'h01)
            r = SC_3;
        else
            r = SC_NONE;
        return r;
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = !drain_reg && !q_full;

    always_comb
    begin
        go       = drain_reg ? !q_full : accept;
        app      = accept && phase_reg != PH_DISCARD && fill_reg < WIN_FILL;
        for (int i = 0; i < WIN; i++)
        begin
            cur[i] = (app && fill_reg == FILL_W'(i)) ? data_byte : win_reg[i];
        end
        fill_cur = fill_reg + {{(FILL_W-1){1'b0}}, app};
        avail1   = (fill_cur == '0) ? '0 : fill_cur - ONE;
        eof_mode = drain_reg || (accept && last_byte);
        sc0      = sc_at(cur[0], cur[1], cur[2], cur[3], fill_cur);
        sc1      = sc_at(cur[1], cur[2], cur[3], cur[4], avail1);
        proc     = go && phase_reg != PH_DISCARD && fill_cur != '0 &&
                   (fill_cur == WIN_FILL || eof_mode);

        win_next     = cur;
        fill_next    = fill_cur;
        phase_next   = phase_reg;
        sc_left_next = sc_left_reg;
        pic_next     = pic_reg;
        err_next     = err_reg;
        drain_next   = drain_reg;
        rec          = '0;
        do_emit      = 1'b0;
        do_err       = 1'b0;
        err_code     = ERR_NONE;
        pts          = 1'b0;
        ulast        = 1'b0;
        sl           = sc_left_reg;
        nal_type     = (sc0 == SC_4) ? cur[4][4:0] : cur[3][4:0];

        if (proc)
        begin
            unique case (phase_reg)
                PH_FIRST, PH_NEXT:
                begin
                    if (sc0 == SC_NONE || sc0 == SC_END)
                    begin
                        do_err   = 1'b1;
                        err_code = ERR_NO_SC;
                    end
                    else if (fill_cur <= ((sc0 == SC_4) ? FOUR : THREE))
                    begin
                        do_err   = 1'b1;
                        err_code = ERR_SC_AT_END;
                    end
                    else
                    begin
                        pts            = nal_type == NAL_SLICE || nal_type == NAL_IDR;
                        rec.unit_first = 1'b1;
                        rec.pts_valid  = pts;
                        rec.timestamp  = pts ? pic_reg : 32'd0;
                        pic_next       = pic_reg + {31'd0, pts};
                        sc_left_next   = (sc0 == SC_4) ? 2'd3 : 2'd2;
                        phase_next     = PH_SC;
                        do_emit        = 1'b1;
                    end
                end
                PH_SC:
                begin
                    do_emit      = 1'b1;
                    sl           = sc_left_reg - {1'b0, sc_left_reg != 2'd0};
                    sc_left_next = sl;
                    if (sl == 2'd0)
                        phase_next = PH_NAL_FIRST;
                end
                PH_NAL_FIRST, PH_BODY:
                begin
                    if (phase_reg == PH_NAL_FIRST && sc0 != SC_NONE)
                    begin
                        do_err   = 1'b1;
                        err_code = ERR_ADJ_SC;
                    end
                    else
                    begin
                        ulast         = sc1 != SC_NONE;
                        rec.unit_last = ulast;
                        phase_next    = ulast ? PH_NEXT : PH_BODY;
                        do_emit       = 1'b1;
                    end
                end
                PH_DISCARD:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (do_emit)
        begin
            rec.has_byte = 1'b1;
            rec.data     = cur[0];
            for (int i = 0; i < WIN - 1; i++)
            begin
                win_next[i] = cur[i + 1];
            end
            win_next[WIN-1] = 8'h00;
            fill_next       = fill_cur - ONE;
        end

        if (do_err)
        begin
            rec.error_code = err_code;
            err_next       = err_code;
            phase_next     = PH_DISCARD;
            fill_next      = '0;
        end

        cont   = phase_next != PH_DISCARD && fill_next != '0;
        q_push = 1'b0;

        if (go && eof_mode)
        begin
            q_push = 1'b1;
            if (!proc)
            begin
                rec            = '0;
                rec.error_code = err_reg;
            end
            rec.stream_end = !proc || !cont;
            drain_next     = proc && cont;
            if (rec.stream_end)
            begin
                phase_next   = PH_FIRST;
                fill_next    = '0;
                sc_left_next = 2'd0;
                pic_next     = 32'd0;
                err_next     = ERR_NONE;
            end
        end
        else
        begin
            q_push = proc;
        end

        q_rec = rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_FIRST;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            sc_left_reg <= 2'd0;
            pic_reg     <= 32'd0;
            err_reg     <= ERR_NONE;
            drain_reg   <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            sc_left_reg <= sc_left_next;
            pic_reg     <= pic_next;
            err_reg     <= err_next;
            drain_reg   <= drain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    `ANNEXB_ASSERT_IMP(a_discard_empty, clk, rst_n, phase_reg == PH_DISCARD, fill_reg == '0)
    `ANNEXB_ASSERT_IMP(a_drain_busy, clk, rst_n, drain_reg, phase_reg != PH_DISCARD && fill_reg != '0)
    `ANNEXB_ASSERT_NEXT(a_end_rearm, clk, rst_n, q_push && q_rec.stream_end, phase_reg == PH_FIRST && fill_reg == '0 && pic_reg == '0 && !drain_reg)

endmodule

/* rtl/annexb_queue.sv */
module annexb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  annexb_pkg::unit_rec_t push_rec,
    output logic                  full,
    input  logic                  pop,
    output logic                  valid,
    output annexb_pkg::unit_rec_t pop_rec
);
    import annexb_pkg::*;

    `include "annexb_nal_packetizer_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    unit_rec_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == DEPTH_CNT;
    assign valid   = cnt_reg != '0;
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_ONE;
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    `ANNEXB_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full)
    `ANNEXB_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, valid)

endmodule

/* rtl/annexb_back.sv */
module annexb_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  q_valid,
    input  annexb_pkg::unit_rec_t q_rec,
    output logic                  q_pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  packet_first,
    output logic                  packet_last,
    output logic                  unit_first,
    output logic                  unit_last,
    output logic                  pts_valid,
    output logic [31:0]           timestamp,
    output logic [1:0]            error_code,
    output logic                  stream_end
);
    import annexb_pkg::*;

    `include "annexb_nal_packetizer_macros.svh"

    logic [15:0] max_reg;
    logic [15:0] pkt_cnt_reg, pkt_cnt_next;
    logic        res_valid_reg, res_valid_next;
    unit_rec_t   rec_reg;
    logic        pf_reg, pl_reg;

    logic [16:0] limit, cnt1;
    logic        load, pf, pl;

    always_comb
    begin
        load           = q_valid && (!res_valid_reg || res_ready);
        limit          = (max_reg == 16'd0) ? 17'h10000 : {1'b0, max_reg};
        cnt1           = {1'b0, pkt_cnt_reg} + 17'd1;
        pf             = q_rec.has_byte && pkt_cnt_reg == 16'd0;
        pl             = q_rec.has_byte && (q_rec.unit_last || cnt1 >= limit);
        pkt_cnt_next   = pkt_cnt_reg;
        res_valid_next = res_valid_reg;
        if (res_ready)
            res_valid_next = 1'b0;
        if (load)
        begin
            res_valid_next = 1'b1;
            if (q_rec.has_byte)
                pkt_cnt_next = pl ? 16'd0 : cnt1[15:0];
            if (q_rec.stream_end)
                pkt_cnt_next = 16'd0;
        end
    end

    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_PKT_RESET;
            pkt_cnt_reg   <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_reg <= cfg_wr_data;
            pkt_cnt_reg   <= pkt_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= q_rec;
            pf_reg  <= pf;
            pl_reg  <= pl;
        end
    end

    assign res_valid    = res_valid_reg;
    assign out_valid    = rec_reg.has_byte;
    assign out_byte     = rec_reg.data;
    assign packet_first = pf_reg;
    assign packet_last  = pl_reg;
    assign unit_first   = rec_reg.unit_first;
    assign unit_last    = rec_reg.unit_last;
    assign pts_valid    = rec_reg.pts_valid;
    assign timestamp    = rec_reg.timestamp;
    assign error_code   = rec_reg.error_code;
    assign stream_end   = rec_reg.stream_end;

    `ANNEXB_ASSERT_NEXT(a_pkt_end_clears, clk, rst_n, q_pop && (q_rec.stream_end || (q_rec.has_byte && q_rec.unit_last)), pkt_cnt_reg == 16'd0)

endmodule

/* rtl/annexb_nal_packetizer.sv */
// Annex B start-code splitter and packetizer.
// Input channel in_valid/in_ready carries one stream byte per beat, with
// last_byte set on the final byte of a file. Output channel
// res_valid/res_ready carries one result beat: a payload byte with packet,
// unit and timestamp marks, an error beat, or an end-of-file marker.
// Bytes are judged at the oldest slot of a lookahead window of 5 or 6
// bytes, so results trail input by the window depth minus one bytes.
// res_valid rises once the result has passed the queue and the output register.
// Throughput is one byte per cycle while the queue has room; the end-of-file
// beat drains the window at one result per cycle, again while the queue has
// room, up to 6 results, with in_ready low until the drain is done.
// The window shift and classification step sets the one-per-cycle figure.
// cfg_wr_en/cfg_wr_data write the packet size limit; write only when idle.
// Reset empties the window and queue and clears the phase and counters; the limit returns
// to 4096. After the end-of-file result the stream state re-arms itself.
// If res_ready is low the output holds; a two-beat queue takes up the
// slack, then in_ready drops until the receiver takes results again.
module annexb_nal_packetizer #(
    parameter int LOOKAHEAD_DEPTH = annexb_pkg::DEF_LOOKAHEAD_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        packet_first,
    output logic        packet_last,
    output logic        unit_first,
    output logic        unit_last,
    output logic        pts_valid,
    output logic [31:0] timestamp,
    output logic [1:0]  error_code,
    output logic        stream_end
);
    import annexb_pkg::*;

    logic      q_full, q_push, q_valid, q_pop;
    unit_rec_t push_rec, pop_rec;

    annexb_front #(
        .LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (push_rec)
    );

    annexb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_rec  (pop_rec)
    );

    annexb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .q_valid      (q_valid),
        .q_rec        (pop_rec),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .packet_first (packet_first),
        .packet_last  (packet_last),
        .unit_first   (unit_first),
        .unit_last    (unit_last),
        .pts_valid    (pts_valid),
        .timestamp    (timestamp),
        .error_code   (error_code),
        .stream_end   (stream_end)
    );

endmodule
